### design/i2c_multi_target_register_responder_unit_defines.svh
// assertion macros for the i2c multi target register responder
`ifndef I2C_MULTI_TARGET_REGISTER_RESPONDER_UNIT_DEFINES_SVH
`define I2C_MULTI_TARGET_REGISTER_RESPONDER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define I2CMTR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define I2CMTR_ASSERT_NEVER(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) not (prop)) else $error(msg);
`else
`define I2CMTR_ASSERT(lbl, prop, msg)
`define I2CMTR_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

### design/i2cmtr_pkg.sv
// shared types and constants for the i2c multi target register responder
package i2cmtr_pkg;

	localparam int unsigned ADDR_SPACE = 128;
	localparam int unsigned ADDR_W     = 7;
	localparam int unsigned SLOT_W     = 4;

	localparam logic [ADDR_W-1:0] RESERVED_LOW  = 7'h07;
	localparam logic [ADDR_W-1:0] RESERVED_HIGH = 7'h78;
	localparam logic [7:0]        UNMAPPED_READ = 8'hFF;
	localparam logic [SLOT_W-1:0] NO_DEVICE     = 4'hF;

	localparam logic [1:0] CMD_BUS    = 2'd0;
	localparam logic [1:0] CMD_ATTACH = 2'd1;
	localparam logic [1:0] CMD_MAP    = 2'd2;

	localparam logic [1:0] PATH_IDLE = 2'd0;
	localparam logic [1:0] PATH_RX   = 2'd1;
	localparam logic [1:0] PATH_TX   = 2'd2;

	localparam logic [3:0] EV_ADDR_WRITE   = 4'd0;
	localparam logic [3:0] EV_ADDR_READ    = 4'd1;
	localparam logic [3:0] EV_ADDR_UNKNOWN = 4'd2;
	localparam logic [3:0] EV_PTR_SET      = 4'd3;
	localparam logic [3:0] EV_WR_REFUSED   = 4'd4;
	localparam logic [3:0] EV_STRAY        = 4'd5;
	localparam logic [3:0] EV_ATT_OK       = 4'd6;
	localparam logic [3:0] EV_ATT_BAD      = 4'd7;
	localparam logic [3:0] EV_ATT_RESERVED = 4'd8;
	localparam logic [3:0] EV_ATT_IN_USE   = 4'd9;
	localparam logic [3:0] EV_ATT_FULL     = 4'd10;
	localparam logic [3:0] EV_MAP_STORED   = 4'd11;
	localparam logic [3:0] EV_MAP_REFUSED  = 4'd12;

	typedef struct packed {
		logic [1:0]        command;
		logic              is_data;
		logic [7:0]        bus_byte;
		logic [ADDR_W-1:0] dev_addr;
		logic [8:0]        map_length;
		logic [7:0]        map_index;
		logic [7:0]        map_value;
	} in_item_t;

	typedef struct packed {
		logic       ack;
		logic [1:0] next_path;
		logic [7:0] read_data;
		logic [3:0] event_res;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_FETCH
	} ctrl_state_t;

	typedef struct packed {
		logic take;
		logic commit;
		logic finish;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic need_fetch;
		logic no_result;
	} dp_status_t;

endpackage

### design/i2c_multi_target_register_responder_unit.sv
// i2c multi target register responder: top level
// an item passes through the address-to-slot ram read and then a step that decides and
// updates the tables; an address byte with the read flag also takes the register map ram
// read behind the slot lookup
// one item is in work at a time; the result register frees the input side while it waits
// reset clears the slot valid bits, device count, active device and pointers; no clearing pass
module i2c_multi_target_register_responder_unit #(
	parameter int unsigned MAX_DEVICES = 8,
	parameter int unsigned MAP_DEPTH   = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  i2cmtr_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output i2cmtr_pkg::out_item_t out_data
);
	import i2cmtr_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	i2cmtr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	i2cmtr_dp #(
		.MAX_DEVICES (MAX_DEVICES),
		.MAP_DEPTH   (MAP_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.status   (status),
		.out_data (out_data)
	);
endmodule

### design/i2cmtr_ram.sv
// generic single write port ram with registered read
module i2cmtr_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                                        clk,
	input  logic                                        wr_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
	input  logic [WIDTH-1:0]                            wr_data,
	input  logic                                        rd_en,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
	output logic [WIDTH-1:0]                            rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

### design/i2cmtr_ctrl.sv
// sequencing state machine and output valid for the responder
`include "i2c_multi_target_register_responder_unit_defines.svh"
module i2cmtr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	output logic                   out_valid,
	input  logic                   out_stall,
	input  i2cmtr_pkg::dp_status_t status,
	output i2cmtr_pkg::dp_cmd_t    cmd
);
	import i2cmtr_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				if (status.no_result) begin
					state_d = S_IDLE;
				end else if (status.need_fetch) begin
					state_d = S_FETCH;
				end else if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				cmd.take = in_valid;
			end
			S_LOOKUP: begin
				// a read commits at once, its result waits for the map data
				if (!status.no_result) begin
					if (status.need_fetch) begin
						cmd.commit = 1'b1;
					end else if (out_free) begin
						cmd.commit   = 1'b1;
						cmd.load_out = 1'b1;
					end
				end
			end
			S_FETCH: begin
				if (out_free) begin
					cmd.finish   = 1'b1;
					cmd.load_out = 1'b1;
				end
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`I2CMTR_ASSERT(a_accept_to_lookup, (in_valid && !in_stall) |=> (state_q == S_LOOKUP), "accepted item did not enter lookup")
	`I2CMTR_ASSERT(a_load_when_free, cmd.load_out |-> (!out_valid_q || !out_stall), "result overwrote a pending item")
	`I2CMTR_ASSERT(a_fetch_from_lookup, (state_q == S_FETCH) |-> ($past(state_q) == S_LOOKUP || $past(state_q) == S_FETCH), "fetch entered without lookup")
	`I2CMTR_ASSERT_NEVER(a_no_result_load, (state_q == S_LOOKUP) && status.no_result && (cmd.load_out || cmd.commit), "ignored command produced an item")
endmodule

### design/i2cmtr_dp.sv
// datapath: device tables, register map store and result register
module i2cmtr_dp #(
	parameter int unsigned MAX_DEVICES = 8,
	parameter int unsigned MAP_DEPTH   = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  i2cmtr_pkg::in_item_t   in_data,
	input  i2cmtr_pkg::dp_cmd_t    cmd,
	output i2cmtr_pkg::dp_status_t status,
	output i2cmtr_pkg::out_item_t  out_data
);
	import i2cmtr_pkg::*;

	localparam int unsigned IDX_W     = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
	localparam int unsigned MAP_WORDS = MAX_DEVICES * MAP_DEPTH;
	localparam int unsigned MAP_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	// item under work and slot lookup result
	in_item_t          item_s1;
	logic              slot_vld_s1;
	logic [SLOT_W-1:0] slot_raw;
	logic              hit;
	logic [IDX_W-1:0]  slot_idx;
	logic [ADDR_W-1:0] lookup_addr;

	// device state
	logic [ADDR_SPACE-1:0] slot_vld_q;
	logic [SLOT_W-1:0]     attached_count_q;
	logic                  active_vld_q;
	logic [IDX_W-1:0]      active_idx_q;
	logic                  taken_q;
	logic [7:0]            dev_ptr_q [MAX_DEVICES];
	logic [8:0]            map_len_q [MAX_DEVICES];
	logic                  in_map_q;
	out_item_t             out_q;

	// next values and write strobes
	logic             nxt_active_vld;
	logic [IDX_W-1:0] nxt_active_idx;
	logic             nxt_taken;
	logic             ptr_we;
	logic [IDX_W-1:0] ptr_widx;
	logic [7:0]       ptr_wdata;
	logic             attach_we;
	logic             map_we;
	logic             map_re;
	logic [MAP_AW-1:0] map_waddr;
	logic [MAP_AW-1:0] map_raddr;
	logic [7:0]       map_rdata;
	logic [7:0]       cur_ptr;
	logic [8:0]       cur_len;
	logic             in_map;
	logic             need_fetch;
	logic             no_result;
	out_item_t        res;
	out_item_t        fetch_res;

	assign lookup_addr = (in_data.command == CMD_BUS) ? in_data.bus_byte[7:1] : in_data.dev_addr;

	i2cmtr_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(ADDR_SPACE)
	) u_slot_ram (
		.clk     (clk),
		.wr_en   (attach_we),
		.wr_addr (item_s1.dev_addr),
		.wr_data (attached_count_q),
		.rd_en   (cmd.take),
		.rd_addr (lookup_addr),
		.rd_data (slot_raw)
	);

	i2cmtr_ram #(
		.WIDTH(8),
		.DEPTH(MAP_WORDS)
	) u_map_ram (
		.clk     (clk),
		.wr_en   (map_we),
		.wr_addr (map_waddr),
		.wr_data (item_s1.map_value),
		.rd_en   (map_re),
		.rd_addr (map_raddr),
		.rd_data (map_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			item_s1     <= in_data;
			slot_vld_s1 <= slot_vld_q[lookup_addr];
		end
	end

	assign hit      = slot_vld_s1 && (slot_raw < SLOT_W'(MAX_DEVICES));
	assign slot_idx = slot_raw[IDX_W-1:0];
	assign cur_ptr  = dev_ptr_q[slot_idx];
	assign cur_len  = map_len_q[slot_idx];
	assign in_map   = ({1'b0, cur_ptr} < cur_len) && ({1'b0, cur_ptr} < 9'(MAP_DEPTH));

	assign map_raddr = MAP_AW'(slot_idx) * MAP_AW'(MAP_DEPTH) + MAP_AW'(cur_ptr);
	assign map_waddr = MAP_AW'(slot_idx) * MAP_AW'(MAP_DEPTH) + MAP_AW'(item_s1.map_index);

	always_comb begin
		res            = '0;
		need_fetch     = 1'b0;
		no_result      = 1'b0;
		nxt_active_vld = active_vld_q;
		nxt_active_idx = active_idx_q;
		nxt_taken      = taken_q;
		ptr_we         = 1'b0;
		ptr_widx       = active_idx_q;
		ptr_wdata      = item_s1.bus_byte;
		attach_we      = 1'b0;
		map_we         = 1'b0;
		case (item_s1.command)
			CMD_BUS: begin
				if (!item_s1.is_data) begin
					if (!hit) begin
						nxt_active_vld = 1'b0;
						res.event_res  = EV_ADDR_UNKNOWN;
					end else begin
						nxt_active_vld = 1'b1;
						nxt_active_idx = slot_idx;
						nxt_taken      = 1'b0;
						if (item_s1.bus_byte[0]) begin
							need_fetch = 1'b1;
						end else begin
							res.ack       = 1'b1;
							res.next_path = PATH_RX;
							res.event_res = EV_ADDR_WRITE;
						end
					end
				end else if (!active_vld_q) begin
					res.event_res = EV_STRAY;
				end else if (!taken_q) begin
					ptr_we        = 1'b1;
					nxt_taken     = 1'b1;
					res.ack       = 1'b1;
					res.next_path = PATH_RX;
					res.event_res = EV_PTR_SET;
				end else begin
					nxt_active_vld = 1'b0;
					res.event_res  = EV_WR_REFUSED;
				end
			end
			CMD_ATTACH: begin
				if (item_s1.map_length == 9'd0 || item_s1.map_length > 9'(MAP_DEPTH)) begin
					res.event_res = EV_ATT_BAD;
				end else if (item_s1.dev_addr <= RESERVED_LOW ||
						item_s1.dev_addr >= RESERVED_HIGH) begin
					res.event_res = EV_ATT_RESERVED;
				end else if (hit) begin
					res.event_res = EV_ATT_IN_USE;
				end else if (attached_count_q >= SLOT_W'(MAX_DEVICES)) begin
					res.event_res = EV_ATT_FULL;
				end else begin
					attach_we     = 1'b1;
					ptr_we        = 1'b1;
					ptr_widx      = attached_count_q[IDX_W-1:0];
					ptr_wdata     = 8'd0;
					res.event_res = EV_ATT_OK;
				end
			end
			CMD_MAP: begin
				if (!hit || {1'b0, item_s1.map_index} >= cur_len ||
						{1'b0, item_s1.map_index} >= 9'(MAP_DEPTH)) begin
					res.event_res = EV_MAP_REFUSED;
				end else begin
					map_we        = 1'b1;
					res.event_res = EV_MAP_STORED;
				end
			end
			default: begin
				no_result = 1'b1;
			end
		endcase
		// strobes only fire on the commit cycle
		ptr_we    = ptr_we && cmd.commit;
		attach_we = attach_we && cmd.commit;
		map_we    = map_we && cmd.commit;
	end

	assign map_re = cmd.commit && need_fetch && in_map;

	assign status.need_fetch = need_fetch;
	assign status.no_result  = no_result;

	always_comb begin
		fetch_res           = '0;
		fetch_res.ack       = 1'b1;
		fetch_res.next_path = PATH_TX;
		fetch_res.read_data = in_map_q ? map_rdata : UNMAPPED_READ;
		fetch_res.event_res = EV_ADDR_READ;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q       <= '0;
			attached_count_q <= '0;
			active_vld_q     <= 1'b0;
			taken_q          <= 1'b0;
			for (int i = 0; i < MAX_DEVICES; i++) begin
				dev_ptr_q[i] <= 8'd0;
			end
		end else if (cmd.commit) begin
			active_vld_q <= nxt_active_vld;
			taken_q      <= nxt_taken;
			if (ptr_we) begin
				dev_ptr_q[ptr_widx] <= ptr_wdata;
			end
			if (attach_we) begin
				slot_vld_q[item_s1.dev_addr] <= 1'b1;
				attached_count_q             <= attached_count_q + SLOT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			active_idx_q <= nxt_active_idx;
			in_map_q     <= in_map;
			if (attach_we) begin
				map_len_q[attached_count_q[IDX_W-1:0]] <= item_s1.map_length;
			end
		end
		if (cmd.load_out) begin
			out_q <= cmd.finish ? fetch_res : res;
		end
	end

	assign out_data = out_q;
endmodule

### dv/i2cmtr_checker.sv
// checker for the i2c multi target register responder: predicts each result item and compares
`timescale 1ns / 1ps

module i2cmtr_checker #(
	parameter int unsigned MAX_DEVICES = 8,
	parameter int unsigned MAP_DEPTH   = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_stall,
	input  i2cmtr_pkg::in_item_t  in_data,
	input  logic                  out_valid,
	input  logic                  out_stall,
	input  i2cmtr_pkg::out_item_t out_data,
	output int                    fail_count,
	output int                    pending,
	output int                    checked,
	output logic [15:0]           events_seen
);
	import i2cmtr_pkg::*;

	logic [SLOT_W-1:0] slot_of_addr [ADDR_SPACE];
	int unsigned       dev_count;
	logic [SLOT_W-1:0] cur_slot;
	logic              ptr_taken;
	logic [7:0]        dev_ptr [MAX_DEVICES];
	logic [8:0]        dev_len [MAX_DEVICES];
	logic [7:0]        reg_map [MAX_DEVICES][MAP_DEPTH];
	out_item_t         expected_q [$];
	int                fails;
	int                seen;
	logic [15:0]       ev_mask;

	function automatic logic [SLOT_W-1:0] lookup(input logic [ADDR_W-1:0] a);
		if (slot_of_addr[a] < MAX_DEVICES)
			return slot_of_addr[a];
		return NO_DEVICE;
	endfunction

	function automatic logic [7:0] reg_at_pointer(input logic [SLOT_W-1:0] s);
		if (dev_ptr[s] < dev_len[s] && dev_ptr[s] < MAP_DEPTH)
			return reg_map[s][dev_ptr[s]];
		return UNMAPPED_READ;
	endfunction

	// updates the device tables for one item; returns 0 when the item yields no result
	function automatic bit respond(input in_item_t it, output out_item_t r);
		logic [SLOT_W-1:0] s;
		r = '0;
		case (it.command)
		CMD_BUS: begin
			if (!it.is_data) begin
				s = lookup(it.bus_byte[7:1]);
				if (s == NO_DEVICE) begin
					cur_slot = NO_DEVICE;
					r.event_res = EV_ADDR_UNKNOWN;
				end else begin
					cur_slot = s;
					ptr_taken = 1'b0;
					r.ack = 1'b1;
					if (it.bus_byte[0]) begin
						r.next_path = PATH_TX;
						r.read_data = reg_at_pointer(s);
						r.event_res = EV_ADDR_READ;
					end else begin
						r.next_path = PATH_RX;
						r.event_res = EV_ADDR_WRITE;
					end
				end
			end else if (cur_slot >= MAX_DEVICES) begin
				cur_slot = NO_DEVICE;
				r.event_res = EV_STRAY;
			end else if (!ptr_taken) begin
				dev_ptr[cur_slot] = it.bus_byte;
				ptr_taken = 1'b1;
				r.ack = 1'b1;
				r.next_path = PATH_RX;
				r.event_res = EV_PTR_SET;
			end else begin
				// second data byte after an address drops the device
				cur_slot = NO_DEVICE;
				r.event_res = EV_WR_REFUSED;
			end
		end
		CMD_ATTACH: begin
			if (it.map_length == 0 || it.map_length > MAP_DEPTH)
				r.event_res = EV_ATT_BAD;
			else if (it.dev_addr <= RESERVED_LOW || it.dev_addr >= RESERVED_HIGH)
				r.event_res = EV_ATT_RESERVED;
			else if (lookup(it.dev_addr) != NO_DEVICE)
				r.event_res = EV_ATT_IN_USE;
			else if (dev_count >= MAX_DEVICES)
				r.event_res = EV_ATT_FULL;
			else begin
				dev_len[dev_count] = it.map_length;
				dev_ptr[dev_count] = '0;
				slot_of_addr[it.dev_addr] = SLOT_W'(dev_count);
				dev_count++;
				r.event_res = EV_ATT_OK;
			end
		end
		CMD_MAP: begin
			s = lookup(it.dev_addr);
			if (s == NO_DEVICE || it.map_index >= dev_len[s] || it.map_index >= MAP_DEPTH)
				r.event_res = EV_MAP_REFUSED;
			else begin
				reg_map[s][it.map_index] = it.map_value;
				r.event_res = EV_MAP_STORED;
			end
		end
		default: begin
			return 1'b0;
		end
		endcase
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int a = 0; a < ADDR_SPACE; a++)
				slot_of_addr[a] = NO_DEVICE;
			for (int k = 0; k < MAX_DEVICES; k++)
				dev_ptr[k] = '0;
			dev_count = 0;
			cur_slot = NO_DEVICE;
			ptr_taken = 1'b0;
			expected_q.delete();
			fails = 0;
			seen = 0;
			ev_mask = '0;
		end else begin
			// results first: an item accepted in this cycle cannot have its result yet
			if (out_valid && !out_stall) begin
				seen++;
				if (expected_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("%0t: result item with nothing expected: ack %0b path %0d data %02h event %0d",
							$time, out_data.ack, out_data.next_path, out_data.read_data,
							out_data.event_res);
				end else begin
					want = expected_q.pop_front();
					ev_mask[want.event_res] = 1'b1;
					if (out_data.ack !== want.ack || out_data.next_path !== want.next_path ||
						out_data.read_data !== want.read_data ||
						out_data.event_res !== want.event_res) begin
						fails++;
						if (fails <= 10)
							$display("%0t: mismatch: expected ack %0b path %0d data %02h event %0d, got ack %0b path %0d data %02h event %0d",
								$time, want.ack, want.next_path, want.read_data, want.event_res,
								out_data.ack, out_data.next_path, out_data.read_data,
								out_data.event_res);
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (respond(in_data, want))
					expected_q.push_back(want);
			end
		end
		fail_count <= fails;
		pending <= expected_q.size();
		checked <= seen;
		events_seen <= ev_mask;
	end

endmodule

### dv/i2c_multi_target_register_responder_unit_tb.sv
// testbench top for the i2c multi target register responder: stimulus, idling and verdict
`timescale 1ns / 1ps

module i2c_multi_target_register_responder_unit_tb;
	import i2cmtr_pkg::*;

	localparam int unsigned MAX_DEVICES    = 8;
	localparam int unsigned MAP_DEPTH      = 256;
	localparam int          RANDOM_ITEMS   = 1200;
	localparam int          CALM_ITEMS     = 150;
	localparam int          LONG_HOLD      = 300;
	localparam int          WATCHDOG_LIMIT = 3000;
	localparam logic [1:0]  CMD_UNUSED     = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;

	int          fail_count;
	int          pending;
	int          checked;
	logic [15:0] events_seen;

	int               sent_count;
	bit               calm;
	bit               long_hold_done;
	bit               big_done;
	bit               addr_taken [ADDR_SPACE];
	logic [ADDR_W-1:0] dev_list [$];
	int               len_list [$];
	int               idle_cycles;

	i2c_multi_target_register_responder_unit #(
		.MAX_DEVICES(MAX_DEVICES),
		.MAP_DEPTH  (MAP_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	i2cmtr_checker #(
		.MAX_DEVICES(MAX_DEVICES),
		.MAP_DEPTH  (MAP_DEPTH)
	) result_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.events_seen(events_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// don't-care fields carry random bits so every input bit toggles
	function automatic in_item_t noisy_item();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return in_item_t'(r[$bits(in_item_t)-1:0]);
	endfunction

	function automatic in_item_t bus_item(input logic as_data, input logic [7:0] b);
		in_item_t it;
		it = noisy_item();
		it.command = CMD_BUS;
		it.is_data = as_data;
		it.bus_byte = b;
		return it;
	endfunction

	function automatic in_item_t attach_item(input logic [ADDR_W-1:0] a, input logic [8:0] len);
		in_item_t it;
		it = noisy_item();
		it.command = CMD_ATTACH;
		it.dev_addr = a;
		it.map_length = len;
		return it;
	endfunction

	function automatic in_item_t map_item(input logic [ADDR_W-1:0] a, input logic [7:0] idx,
		input logic [7:0] val);
		in_item_t it;
		it = noisy_item();
		it.command = CMD_MAP;
		it.dev_addr = a;
		it.map_index = idx;
		it.map_value = val;
		return it;
	endfunction

	function automatic logic [ADDR_W-1:0] free_addr();
		logic [ADDR_W-1:0] a;
		do
			a = ADDR_W'($urandom_range(RESERVED_LOW + 1, RESERVED_HIGH - 1));
		while (addr_taken[a]);
		return a;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send(input in_item_t it);
		int gap;
		if (!calm && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 14);
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
		if (it.command != CMD_UNUSED)
			sent_count++;
	endtask

	task automatic note_device(input logic [ADDR_W-1:0] a, input int len);
		addr_taken[a] = 1'b1;
		dev_list.push_back(a);
		len_list.push_back(len);
	endtask

	// attach and fill the whole map right away, so no read ever hits an unloaded entry
	task automatic add_device(input int len);
		logic [ADDR_W-1:0] a;
		a = free_addr();
		send(attach_item(a, 9'(len)));
		note_device(a, len);
		for (int i = 0; i < len; i++)
			send(map_item(a, 8'(i), 8'($urandom)));
	endtask

	task automatic talk_to_device(input int k);
		logic [ADDR_W-1:0] a;
		logic [7:0]        ptr;
		a = dev_list[k];
		if ($urandom_range(0, 9) < 7)
			ptr = 8'($urandom_range(0, len_list[k] - 1));
		else
			ptr = 8'($urandom);
		if ($urandom_range(0, 9) < 6) begin
			send(bus_item(1'b0, {a, 1'b0}));
			send(bus_item(1'b1, ptr));
			if ($urandom_range(0, 4) == 0)
				send(bus_item(1'b1, 8'($urandom)));
			repeat ($urandom_range(0, 2))
				send(bus_item(1'b0, {a, 1'b1}));
		end else begin
			send(bus_item(1'b0, {a, 1'b1}));
			if ($urandom_range(0, 2) == 0) begin
				send(bus_item(1'b1, ptr));
				if ($urandom_range(0, 1) == 0)
					send(bus_item(1'b1, 8'($urandom)));
			end
		end
	endtask

	task automatic bad_attach();
		logic [ADDR_W-1:0] a;
		logic [8:0]        good_len;
		int                kind;
		kind = $urandom_range(0, 3);
		good_len = 9'($urandom_range(1, MAP_DEPTH));
		if (kind == 3 && dev_list.size() < MAX_DEVICES)
			kind = 2;
		if (kind == 2 && dev_list.size() == 0)
			kind = 1;
		case (kind)
		0: send(attach_item(ADDR_W'($urandom),
			$urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(MAP_DEPTH + 1, 511))));
		1: begin
			if ($urandom_range(0, 1))
				a = ADDR_W'($urandom_range(0, RESERVED_LOW));
			else
				a = ADDR_W'($urandom_range(RESERVED_HIGH, ADDR_SPACE - 1));
			send(attach_item(a, good_len));
		end
		2: send(attach_item(dev_list[$urandom_range(0, dev_list.size() - 1)], good_len));
		default: send(attach_item(free_addr(), good_len));
		endcase
	endtask

	task automatic refused_map();
		int k;
		k = (dev_list.size() == 0) ? -1 : $urandom_range(0, dev_list.size() - 1);
		if (k >= 0 && len_list[k] < MAP_DEPTH && $urandom_range(0, 1))
			send(map_item(dev_list[k], 8'($urandom_range(len_list[k], 255)), 8'($urandom)));
		else
			send(map_item(free_addr(), 8'($urandom), 8'($urandom)));
	endtask

	task automatic noise_item();
		in_item_t it;
		it = noisy_item();
		case ($urandom_range(0, 4))
		0: it.command = CMD_MAP;
		1: it.command = CMD_UNUSED;
		default: it.command = CMD_BUS;
		endcase
		send(it);
	endtask

	// receiver side: random stall bursts, one long hold so the block backs up
	initial begin
		int n;
		out_stall <= 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!long_hold_done && sent_count >= 300) begin
				long_hold_done = 1'b1;
				out_stall <= 1'b1;
				n = LONG_HOLD;
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				n = $urandom_range(1, 14);
			end else begin
				out_stall <= 1'b0;
				n = $urandom_range(1, 20);
			end
			repeat (n) @(negedge clk);
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles, %0d results outstanding",
				idle_cycles, pending);
			$display("TEST FAILED");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		int stop_at;
		int r;
		int len;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		sent_count = 0;
		calm = 1'b0;
		long_hold_done = 1'b0;
		big_done = 1'b0;
		for (int a = 0; a < ADDR_SPACE; a++)
			addr_taken[a] = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: address and data byte extremes with no device
		send(bus_item(1'b0, 8'h00));
		send(bus_item(1'b0, 8'hFF));
		send(bus_item(1'b1, 8'hFF));
		// attach checks in priority order
		send(attach_item(7'h00, 9'd511));
		send(attach_item(7'h20, 9'd0));
		send(attach_item(RESERVED_LOW, 9'd1));
		send(attach_item(RESERVED_HIGH, 9'(MAP_DEPTH)));
		send(map_item(RESERVED_LOW + 7'd1, 8'h00, 8'h11));
		send(attach_item(RESERVED_LOW + 7'd1, 9'd1));
		note_device(RESERVED_LOW + 7'd1, 1);
		send(attach_item(RESERVED_LOW + 7'd1, 9'(MAP_DEPTH)));
		send(map_item(RESERVED_LOW + 7'd1, 8'h00, 8'h5A));
		send(map_item(RESERVED_LOW + 7'd1, 8'h01, 8'h33));
		// read, then data after a read sets the pointer, then refused write, then stray
		send(bus_item(1'b0, {RESERVED_LOW + 7'd1, 1'b1}));
		send(bus_item(1'b1, 8'h00));
		send(bus_item(1'b1, 8'hAA));
		send(bus_item(1'b1, 8'h01));
		// pointer past the map reads the filler byte
		send(bus_item(1'b0, {RESERVED_LOW + 7'd1, 1'b0}));
		send(bus_item(1'b1, 8'hFF));
		send(bus_item(1'b0, {RESERVED_LOW + 7'd1, 1'b1}));
		begin
			in_item_t it;
			it = noisy_item();
			it.command = CMD_UNUSED;
			send(it);
		end
		send(attach_item(RESERVED_HIGH - 7'd1, 9'd2));
		note_device(RESERVED_HIGH - 7'd1, 2);
		send(map_item(RESERVED_HIGH - 7'd1, 8'h00, 8'hFF));
		send(map_item(RESERVED_HIGH - 7'd1, 8'h01, 8'h00));
		send(bus_item(1'b0, {RESERVED_HIGH - 7'd1, 1'b0}));
		send(bus_item(1'b1, 8'h01));
		send(bus_item(1'b0, {RESERVED_HIGH - 7'd1, 1'b1}));

		// random: mostly well-formed transfers to attached devices
		stop_at = sent_count + RANDOM_ITEMS;
		while (sent_count < stop_at) begin
			calm = (sent_count >= stop_at - CALM_ITEMS);
			r = $urandom_range(0, 99);
			if (dev_list.size() < MAX_DEVICES && r < 6) begin
				if (!big_done && dev_list.size() >= 3) begin
					len = MAP_DEPTH;
					big_done = 1'b1;
				end else
					len = $urandom_range(1, 12);
				add_device(len);
			end else if (dev_list.size() != 0 && r < 60)
				talk_to_device($urandom_range(0, dev_list.size() - 1));
			else if (dev_list.size() != 0 && r < 70) begin
				len = $urandom_range(0, dev_list.size() - 1);
				send(map_item(dev_list[len], 8'($urandom_range(0, len_list[len] - 1)),
					8'($urandom)));
			end else if (r < 78)
				bad_attach();
			else if (r < 84)
				refused_map();
			else
				noise_item();
		end
		in_valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		$display("run covered %0d items, %0d result items checked, %0d devices attached",
			sent_count, checked, dev_list.size());
		$display("event codes observed (bit per code): %b", events_seen);
		if (fail_count == 0)
			$display("TEST PASSED");
		else begin
			$display("%0d failures", fail_count);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
